// File: rtl/ardl_pkg.sv
// Package for the adaptive ratio distortion lowpass core.
// Holds widths, constants, register indexes and the divider control struct; no dependencies.
package ardl_pkg;
	localparam int SampleBits    = 24;
	localparam int LevelFracBits = 20;
	localparam int GainFrac      = 14;
	localparam int CoefFrac      = 30;
	localparam int KHold         = 59638;
	localparam int KRatio        = 5898;
	localparam int DivBits       = 64;

	typedef enum logic [2:0] {
		REG_IN_GAIN  = 3'd0,
		REG_OUT_GAIN = 3'd1,
		REG_DRIVE    = 3'd2,
		REG_B0       = 3'd3,
		REG_B1       = 3'd4,
		REG_B2       = 3'd5,
		REG_A1       = 3'd6,
		REG_A2       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// File: rtl/ardl_div.sv
// Shared restoring divider for the level core: one quotient bit per cycle.
// Depends on ardl_pkg. Division by zero returns all ones, or zero for zero dividend.
module ardl_div
	import ardl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DivBits-1:0] num,
	input  logic [DivBits-1:0] den,
	output div_ctl_t           ctl,
	output logic [DivBits-1:0] quo
);
	logic [DivBits-1:0] rem_q;
	logic [DivBits-1:0] quo_q;
	logic [DivBits-1:0] den_q;
	logic [6:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DivBits:0]   trial;
	logic [DivBits:0]   diff;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[DivBits-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(DivBits);
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
			end else if (busy_q) begin
				if (den_q == '0) begin
					quo_q  <= (quo_q == '0) ? '0 : '1;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					if (!diff[DivBits]) rem_q <= diff[DivBits-1:0];
					else rem_q <= trial[DivBits-1:0];
					quo_q <= {quo_q[DivBits-2:0], ~diff[DivBits]};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	assign quo = quo_q;
	assign ctl = '{start: start, busy: busy_q, done: done_q};

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("divider did not start");
`endif
endmodule

// File: rtl/adaptive_ratio_distortion_lowpass_core.sv
// Top level of the adaptive ratio distortion lowpass core.
// Depends on ardl_pkg and ardl_div.
//
//  channel | signals                                | direction
//  in      | in_valid, in_stall, left_in, right_in, mono | into block
//  out     | out_valid, out_stall, left_out, right_out   | out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data   | into block
//
// Each item runs four 64-bit divisions on the shared serial divider and the
// remaining sequencer steps; a zero divisor cuts its division short.
// Reset is asynchronous and brings levels to one, filter state to zero.
// A finished item waits in the output register; the next item is taken
// after it has left. Configuration is always ready.
module adaptive_ratio_distortion_lowpass_core
	import ardl_pkg::*;
#(
	parameter int SAMPLE_BITS     = SampleBits,
	parameter int LEVEL_FRAC_BITS = LevelFracBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	input  logic                          mono,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);
	localparam logic [31:0] LevelOne = 32'(64'd1 << LEVEL_FRAC_BITS);
	localparam logic signed [63:0] FiltMax  = 64'sd2147483647;
	localparam logic signed [63:0] FiltMin  = -64'sd2147483648;
	localparam logic signed [63:0] StateMax = 64'sd140737488355327;
	localparam logic signed [63:0] StateMin = -64'sd140737488355328;
	localparam logic signed [63:0] OutMax   = 64'sd1 <<< (SAMPLE_BITS - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_GAIN_L, S_GAIN_R, S_MID, S_SQ, S_DIV_TERM, S_ANEW,
		S_DIV_RATIO, S_BNEW, S_DIV_L, S_OG_L, S_DIV_R, S_OG_R,
		S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_OUT
	} state_t;

	state_t state_q;
	logic [15:0] in_gain_q, out_gain_q;
	logic [7:0]  drive_q;
	logic signed [31:0] coef_q [5];
	logic [31:0] level_a_q, level_b_q;
	logic signed [47:0] fs_q [2][2];
	logic signed [SAMPLE_BITS-1:0] l_raw_q, r_raw_q;
	logic mono_q;
	logic signed [63:0] l_q, r_q;
	logic [63:0] t_q;
	logic [63:0] lvl_q;
	logic signed [63:0] x_q, y_q;
	logic side_q;
	logic signed [SAMPLE_BITS-1:0] lo_q, ro_q;
	logic out_valid_q;

	// Shared multiplier: one signed 33x33 product per cycle
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	assign prod = mul_a * mul_b;

	logic [DivBits-1:0] div_num, div_den, div_quo;
	logic               div_start;
	div_ctl_t           div_ctl;

	ardl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .ctl(div_ctl), .quo(div_quo)
	);

	function automatic logic [63:0] usat32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction
	function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
		input logic signed [63:0] lo, input logic signed [63:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction
	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction
	function automatic logic [63:0] lvl_shift(input logic [63:0] m, input int fin);
		if (LEVEL_FRAC_BITS >= fin) return m << (LEVEL_FRAC_BITS - fin);
		return m >> (fin - LEVEL_FRAC_BITS);
	endfunction

	// Side data for per-side steps
	logic signed [63:0] side_s;
	assign side_s = side_q ? r_q : l_q;

	// Select multiplier operands by sequencer state
	logic [63:0] anew_c, mid_c;
	assign mid_c = usat32(lvl_shift(mag(l_q + r_q) * {56'd0, drive_q}, SAMPLE_BITS));
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_GAIN_L: begin
				mul_a = 33'(l_raw_q);
				mul_b = {17'd0, in_gain_q};
			end
			S_GAIN_R: begin
				mul_a = 33'(r_raw_q);
				mul_b = {17'd0, in_gain_q};
			end
			S_SQ: begin
				mul_a = {1'b0, t_q[31:0]};
				mul_b = {1'b0, t_q[31:0]};
			end
			S_OG_L, S_OG_R: begin
				mul_a = {1'b0, t_q[31:0]};
				mul_b = {17'd0, out_gain_q};
			end
			S_F0: begin
				mul_a = 33'(coef_q[0]);
				mul_b = 33'($signed(x_q[31:0]));
			end
			S_F1: begin
				mul_a = 33'(coef_q[1]);
				mul_b = 33'($signed(x_q[31:0]));
			end
			S_F2: begin
				mul_a = 33'(coef_q[3]);
				mul_b = 33'($signed(y_q[31:0]));
			end
			S_F3: begin
				mul_a = 33'(coef_q[2]);
				mul_b = 33'($signed(x_q[31:0]));
			end
			S_F4: begin
				mul_a = 33'(coef_q[4]);
				mul_b = 33'($signed(lvl_q[31:0]));
			end
			default: ;
		endcase
	end

	logic signed [63:0] gain_r, cm_r;
	assign gain_r = 64'(prod + 66'sd8192) >>> GainFrac;
	assign cm_r   = 64'((prod + 66'sd536870912) >>> CoefFrac);

	assign anew_c = usat32(((lvl_q + {33'd0, level_b_q[31:1]}) >> 1) + t_q);

	// Start the divider from the states that need a quotient
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			S_DIV_TERM: if (!div_ctl.busy && !div_ctl.done && t_q[63]) begin
				div_start = 1'b1;
				div_num = x_q;
				div_den = {31'd0, level_a_q, 1'b0};
			end
			S_DIV_RATIO: if (!div_ctl.busy && !div_ctl.done && t_q[63]) begin
				div_start = 1'b1;
				div_num = {32'd0, level_a_q} << LEVEL_FRAC_BITS;
				div_den = {32'd0, level_b_q};
			end
			S_DIV_L, S_DIV_R: if (!div_ctl.busy && !div_ctl.done && t_q[63]) begin
				div_start = 1'b1;
				div_num = mag(side_s) << LEVEL_FRAC_BITS;
				div_den = {32'd0, level_a_q};
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign left_out  = lo_q;
	assign right_out = ro_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_gain_q  <= 16'd16384;
			out_gain_q <= 16'd16384;
			drive_q    <= 8'd60;
			coef_q[0]  <= 32'sd1073741824;
			coef_q[1]  <= '0;
			coef_q[2]  <= '0;
			coef_q[3]  <= '0;
			coef_q[4]  <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IN_GAIN:  in_gain_q  <= cfg_data[15:0];
				REG_OUT_GAIN: out_gain_q <= cfg_data[15:0];
				REG_DRIVE:    drive_q    <= cfg_data[7:0];
				REG_B0:       coef_q[0]  <= cfg_data;
				REG_B1:       coef_q[1]  <= cfg_data;
				REG_B2:       coef_q[2]  <= cfg_data;
				REG_A1:       coef_q[3]  <= cfg_data;
				REG_A2:       coef_q[4]  <= cfg_data;
			endcase
		end
	end

	// Sequencer: t_q[63] marks a divide not yet launched
	logic signed [63:0] s0n, s1n, yc;
	always_comb begin
		yc  = clamp(cm_r + 64'(fs_q[side_q][0]), FiltMin, FiltMax);
		s0n = clamp(x_q + 64'(fs_q[side_q][1]) - cm_r, StateMin, StateMax);
		s1n = clamp(y_q - cm_r, StateMin, StateMax);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			level_a_q   <= LevelOne;
			level_b_q   <= LevelOne;
			for (int s = 0; s < 2; s++) begin
				fs_q[s][0] <= '0;
				fs_q[s][1] <= '0;
			end
			side_q <= 1'b0;
			t_q    <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					l_raw_q <= left_in;
					r_raw_q <= right_in;
					mono_q  <= mono;
					state_q <= S_GAIN_L;
				end
				S_GAIN_L: begin
					l_q     <= gain_r;
					state_q <= S_GAIN_R;
				end
				S_GAIN_R: begin
					r_q     <= mono_q ? l_q : gain_r;
					state_q <= S_MID;
				end
				S_MID: begin
					lvl_q   <= usat32(lvl_shift(mag(l_q), SAMPLE_BITS - 1));
					t_q     <= mid_c;
					state_q <= S_SQ;
				end
				S_SQ: begin
					x_q     <= 64'(prod);
					t_q     <= {1'b1, 63'd0};
					state_q <= S_DIV_TERM;
				end
				S_DIV_TERM: begin
					if (div_start) t_q <= '0;
					if (div_ctl.done) begin
						t_q     <= usat32(div_quo);
						state_q <= S_ANEW;
					end
				end
				S_ANEW: begin
					level_a_q <= anew_c[31:0];
					t_q       <= {1'b1, 63'd0};
					state_q   <= S_DIV_RATIO;
				end
				S_DIV_RATIO: begin
					if (div_start) t_q <= '0;
					if (div_ctl.done) begin
						t_q     <= usat32(div_quo);
						state_q <= S_BNEW;
					end
				end
				S_BNEW: begin
					lvl_q <= usat32((64'(KHold) * ({32'd0, level_a_q} +
						(({32'd0, level_b_q} > {32'd0, level_a_q}) ?
						{32'd0, level_b_q - level_a_q} : {32'd0, level_a_q - level_b_q}))
						+ 64'(KRatio) * t_q) >> 16);
					state_q <= S_DIV_L;
					side_q  <= 1'b0;
					t_q     <= {1'b1, 63'd0};
				end
				S_DIV_L, S_DIV_R: begin
					if (state_q == S_DIV_L && !side_q) level_b_q <= lvl_q[31:0];
					if (div_start) t_q <= '0;
					if (div_ctl.done) begin
						t_q     <= usat32(div_quo);
						state_q <= (state_q == S_DIV_L) ? S_OG_L : S_OG_R;
					end
				end
				S_OG_L, S_OG_R: begin
					x_q <= clamp(side_s[63] ? -(64'(prod + 66'sd8192) >> GainFrac)
						: (64'(prod + 66'sd8192) >> GainFrac), FiltMin, FiltMax);
					state_q <= S_F0;
				end
				S_F0: begin
					y_q     <= yc;
					state_q <= S_F1;
				end
				S_F1: begin
					x_q     <= cm_r;
					lvl_q   <= 64'(x_q);
					state_q <= S_F2;
				end
				S_F2: begin
					fs_q[side_q][0] <= 48'(s0n);
					x_q     <= lvl_q;
					state_q <= S_F3;
				end
				S_F3: begin
					y_q     <= cm_r;
					lvl_q   <= 64'(y_q);
					state_q <= S_F4;
				end
				S_F4: begin
					fs_q[side_q][1] <= 48'(s1n);
					if (!side_q) lo_q <= SAMPLE_BITS'(clamp(lvl_q, -OutMax, OutMax - 1));
					else ro_q <= SAMPLE_BITS'(clamp(lvl_q, -OutMax, OutMax - 1));
					state_q <= S_F5;
				end
				S_F5: begin
					if (!side_q) begin
						side_q  <= 1'b1;
						t_q     <= {1'b1, 63'd0};
						state_q <= S_DIV_R;
					end else begin
						side_q      <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// S_F2 uses cm_r as a1*y; S_F1 product b1*x is parked in x_q
	// s0n = b1x + s1 - a1y reads x_q (b1x) at S_F2; S_F4 s1n = b2x - a2y reads y_q.

`ifndef SYNTHESIS
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("item accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(left_out) && $stable(right_out)))
		else $error("stalled output changed");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_ctl.busy) else $error("divider busy while idle");
`endif
endmodule
